[design/uds_pkg.sv]
// ----------------------------------------------------------------------------
// uds_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package uds_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned ERR_W  = 3;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    localparam logic [CP_W-1:0] LEAD_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] LEAD_SURR_HI  = 21'h00DBFF;
    localparam logic [CP_W-1:0] TRAIL_SURR_LO = 21'h00DC00;
    localparam logic [CP_W-1:0] TRAIL_SURR_HI = 21'h00DFFF;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_UNIT   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_PAIRED_SUR = 3'd3;
    localparam logic [ERR_W-1:0] ERR_STRAY_CONT = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNEXP_LEAD = 3'd5;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED  = 3'd6;

    typedef enum logic [2:0] {
        KIND_INVALID = 3'd0,
        KIND_ASCII   = 3'd1,
        KIND_LEAD2   = 3'd2,
        KIND_LEAD3   = 3'd3,
        KIND_LEAD4   = 3'd4,
        KIND_CONT    = 3'd5
    } t_byte_kind;

    typedef struct packed {
        logic [CP_W-1:0]  scalar;
        logic [ERR_W-1:0] status;
        logic             string_end;
    } t_result;

    function automatic t_byte_kind classify(input logic [BYTE_W-1:0] b);
        t_byte_kind k;
        if (b[7] == 1'b0) begin
            k = KIND_ASCII;
        end else if (b[6] == 1'b0) begin
            k = KIND_CONT;
        end else if (b[5] == 1'b0) begin
            k = KIND_LEAD2;
        end else if (b[4] == 1'b0) begin
            k = KIND_LEAD3;
        end else if (b[3] == 1'b0) begin
            k = KIND_LEAD4;
        end else begin
            k = KIND_INVALID;
        end
        return k;
    endfunction

endpackage

[design/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream into code points or one error per string.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  input     i_valid, o_stall, i_data_byte, i_last_byte      byte items in
//  output    o_valid, i_stall, o_scalar, o_status,           results out
//            o_string_end
//
//  One byte per cycle while o_stall is low; each result is registered.
//  Decode is a combinational classify plus shift-or on the sequence state.
//  A one-entry skid behind the output register absorbs a result while the
//  output is stalled; o_stall rises only when that skid is full.
//  Synchronous active-low reset clears sequence state and both valid flags.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_scalar,
    output logic [2:0]  o_status,
    output logic        o_string_end
);

    logic [uds_pkg::CP_W-1:0] r_acc, n_acc;
    logic [1:0]               r_rem, n_rem;
    logic                     r_lead_sur, n_lead_sur;
    logic                     r_discard, n_discard;

    uds_pkg::t_result         r_out, r_skid, res;
    logic                     r_out_valid, r_skid_valid;
    logic                     res_valid;

    logic                     accept;
    logic                     out_free;
    uds_pkg::t_byte_kind      kind;
    logic [uds_pkg::CP_W-1:0] acc_sh;
    logic [1:0]               rem_dec;

    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign kind     = uds_pkg::classify(i_data_byte);
    assign acc_sh   = {r_acc[uds_pkg::CP_W-7:0], i_data_byte[5:0]};
    assign rem_dec  = r_rem - 2'd1;

    always_comb begin
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_lead_sur = r_lead_sur;
        n_discard  = r_discard;
        res_valid  = 1'b0;
        res.scalar     = '0;
        res.status     = uds_pkg::ERR_OK;
        res.string_end = i_last_byte;

        if (r_discard) begin
            res_valid = i_last_byte;
        end else if (kind == uds_pkg::KIND_INVALID) begin
            res_valid  = 1'b1;
            res.status = uds_pkg::ERR_BAD_UNIT;
        end else if (r_rem == 2'd0) begin
            if (kind == uds_pkg::KIND_CONT) begin
                res_valid  = 1'b1;
                res.status = uds_pkg::ERR_STRAY_CONT;
            end else if (kind == uds_pkg::KIND_ASCII) begin
                res_valid  = 1'b1;
                n_lead_sur = 1'b0;
                res.scalar = {13'd0, i_data_byte};
            end else if (i_last_byte) begin
                res_valid  = 1'b1;
                res.status = uds_pkg::ERR_TRUNCATED;
            end else begin
                case (kind)
                    uds_pkg::KIND_LEAD2: begin
                        n_acc = {16'd0, i_data_byte[4:0]};
                        n_rem = 2'd1;
                    end
                    uds_pkg::KIND_LEAD3: begin
                        n_acc = {17'd0, i_data_byte[3:0]};
                        n_rem = 2'd2;
                    end
                    default: begin
                        n_acc = {18'd0, i_data_byte[2:0]};
                        n_rem = 2'd3;
                    end
                endcase
            end
        end else if (kind != uds_pkg::KIND_CONT) begin
            res_valid  = 1'b1;
            res.status = uds_pkg::ERR_UNEXP_LEAD;
        end else if (rem_dec != 2'd0) begin
            if (i_last_byte) begin
                res_valid  = 1'b1;
                res.status = uds_pkg::ERR_TRUNCATED;
            end else begin
                n_acc = acc_sh;
                n_rem = rem_dec;
            end
        end else begin
            res_valid = 1'b1;
            n_acc     = '0;
            n_rem     = 2'd0;
            if (acc_sh > uds_pkg::CP_MAX) begin
                res.status = uds_pkg::ERR_TOO_LARGE;
            end else if (r_lead_sur && acc_sh >= uds_pkg::TRAIL_SURR_LO
                         && acc_sh <= uds_pkg::TRAIL_SURR_HI) begin
                res.status = uds_pkg::ERR_PAIRED_SUR;
            end else begin
                n_lead_sur = (acc_sh >= uds_pkg::LEAD_SURR_LO)
                             && (acc_sh <= uds_pkg::LEAD_SURR_HI);
                res.scalar = acc_sh;
            end
        end

        if (res_valid) begin
            if (i_last_byte) begin
                n_acc      = '0;
                n_rem      = 2'd0;
                n_lead_sur = 1'b0;
                n_discard  = 1'b0;
            end else if (res.status != uds_pkg::ERR_OK) begin
                n_acc      = '0;
                n_rem      = 2'd0;
                n_lead_sur = 1'b0;
                n_discard  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_rem        <= 2'd0;
            r_lead_sur   <= 1'b0;
            r_discard    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_acc      <= n_acc;
                r_rem      <= n_rem;
                r_lead_sur <= n_lead_sur;
                r_discard  <= n_discard;
            end
            // skid is only loaded on accept, which requires it empty
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= accept && res_valid;
                end
            end else if (accept && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept && res_valid) begin
                r_out <= res;
            end
        end else if (accept && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_scalar     = r_out.scalar;
    assign o_status     = r_out.status;
    assign o_string_end = r_out.string_end;

endmodule
